@@ hw/rtl/sup_pkg.sv @@
// ----------------------------------------------------------------------------
// sup_pkg
// shared types and constants of the supervisor automaton step block
// ----------------------------------------------------------------------------
package sup_pkg;

	localparam int STATE_W  = 8;
	localparam int EVENT_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int ENTRY_W  = STATE_W + 1;
	localparam int MARK_W   = 2;
	localparam int ACTION_W = 3;
	localparam int KIND_W   = 2;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;

	typedef enum logic [ACTION_W-1:0] {
		ACT_STEP     = 3'd0,
		ACT_TEST     = 3'd1,
		ACT_LIST     = 3'd2,
		ACT_WR_TRANS = 3'd3,
		ACT_WR_MARKS = 3'd4,
		ACT_RESTART  = 3'd5
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STEP = 2'd0,
		KIND_TEST = 2'd1,
		KIND_LIST = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STEP,
		ST_TEST,
		ST_LIST,
		ST_LIST_END
	} ctl_state_t;

	typedef struct packed {
		logic [EVENT_W-1:0] event_id;
		logic [STATE_W-1:0] table_state;
		logic [STATE_W-1:0] target_state;
		logic               entry_valid;
		logic               in_alphabet;
		logic               is_controllable;
	} item_t;

	typedef struct packed {
		kind_t              result_kind;
		logic               accepted;
		logic               moved;
		logic [STATE_W-1:0] now_state;
		logic [STATE_W-1:0] prior_state;
		logic               event_enabled;
		logic               has_event;
		logic [EVENT_W-1:0] listed_event;
		logic [COUNT_W-1:0] list_count;
		logic               last;
	} result_t;

	typedef struct packed {
		logic clear;
		logic rd_item;
		logic rd_list;
		logic rd_next;
		logic wr_trans;
		logic wr_marks;
		logic restart;
		logic list_eval;
		logic emit_step;
		logic emit_test;
		logic emit_final;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_free;
		logic hit;
		logic pend;
		logic k_last;
	} dp_sts_t;

endpackage

@@ hw/rtl/sup_ram.sv @@
// ----------------------------------------------------------------------------
// sup_ram
// single-port ram with registered read data
// ----------------------------------------------------------------------------
module sup_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

@@ hw/rtl/sup_ctrl.sv @@
// ----------------------------------------------------------------------------
// sup_ctrl
// controller state machine: table clear, item dispatch, event list walk
// ----------------------------------------------------------------------------
module sup_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  sup_pkg::action_t  action,
	output logic              s_tready,
	input  sup_pkg::dp_sts_t  sts,
	output sup_pkg::dp_cmd_t  cmd
);

	import sup_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (action)
						ACT_STEP: begin
							cmd.rd_item = 1'b1;
							state_d     = ST_STEP;
						end
						ACT_TEST: begin
							cmd.rd_item = 1'b1;
							state_d     = ST_TEST;
						end
						ACT_LIST: begin
							cmd.rd_list = 1'b1;
							state_d     = ST_LIST;
						end
						ACT_WR_TRANS: cmd.wr_trans = 1'b1;
						ACT_WR_MARKS: cmd.wr_marks = 1'b1;
						ACT_RESTART:  cmd.restart  = 1'b1;
						default: ;
					endcase
				end
			end
			ST_STEP: begin
				if (sts.out_free) begin
					cmd.emit_step = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_TEST: begin
				if (sts.out_free) begin
					cmd.emit_test = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_LIST: begin
				// a new hit pushes the pending one out, which needs the output slot
				if (!(sts.hit && sts.pend && !sts.out_free)) begin
					cmd.list_eval = 1'b1;
					if (sts.k_last) begin
						state_d = ST_LIST_END;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_LIST_END: begin
				if (sts.out_free) begin
					cmd.emit_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

@@ hw/rtl/sup_dp.sv @@
// ----------------------------------------------------------------------------
// sup_dp
// datapath: transition table, event marks, state registers, result register
// ----------------------------------------------------------------------------
module sup_dp #(
	parameter int NUM_STATES = 256,
	parameter int NUM_EVENTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sup_pkg::dp_cmd_t              cmd,
	output sup_pkg::dp_sts_t              sts,
	input  sup_pkg::item_t                item,
	input  logic                          cfg_we,
	input  logic [sup_pkg::STATE_W-1:0]   cfg_data,
	output sup_pkg::result_t              result,
	output logic                          m_tvalid,
	input  logic                          m_tready
);

	import sup_pkg::*;

	localparam int SW  = $clog2(NUM_STATES);
	localparam int EVB = $clog2(NUM_EVENTS);
	localparam int XW  = (SW > STATE_W) ? SW : STATE_W;
	localparam int AW  = SW + EVB;

	logic [STATE_W-1:0] init_q;
	logic [STATE_W-1:0] cur_q;
	logic [STATE_W-1:0] prev_q;
	logic [AW-1:0]      clr_q;
	logic [EVB-1:0]     k_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [EVB-1:0]     pend_ev_q;
	logic               ev_ok_q;
	logic               m_valid_q;
	result_t            res_q;
	result_t            res_d;

	logic [XW-1:0]      cur_x;
	logic [XW-1:0]      src_x;
	logic               st_ok;
	logic               src_ok;
	logic               in_ev_ok;
	logic [EVB-1:0]     in_ev;
	logic [EVB-1:0]     k_nxt;

	logic [AW-1:0]      tb_addr;
	logic               tb_we;
	logic               tb_re;
	logic [ENTRY_W-1:0] tb_wdata;
	logic [ENTRY_W-1:0] tb_rdata;
	logic [EVB-1:0]     mk_addr;
	logic               mk_we;
	logic [MARK_W-1:0]  mk_wdata;
	logic [MARK_W-1:0]  mk_rdata;

	logic               out_free;
	logic               out_load;
	logic               hit;
	logic               pend;
	logic               in_alpha;
	logic               ent_ok;
	logic               moved;

	assign cur_x    = XW'(cur_q);
	assign src_x    = XW'(item.table_state);
	assign st_ok    = 32'(cur_q) < 32'(NUM_STATES);
	assign src_ok   = 32'(item.table_state) < 32'(NUM_STATES);
	assign in_ev_ok = 32'(item.event_id) < 32'(NUM_EVENTS);
	assign in_ev    = item.event_id[EVB-1:0];
	assign k_nxt    = k_q + 1'b1;

	// table and mark port selection
	always_comb begin
		tb_addr = {cur_x[SW-1:0], in_ev};
		mk_addr = in_ev;
		priority if (cmd.clear) begin
			tb_addr = clr_q;
			mk_addr = clr_q[EVB-1:0];
		end else if (cmd.wr_trans) begin
			tb_addr = {src_x[SW-1:0], in_ev};
		end else if (cmd.rd_list) begin
			tb_addr = {cur_x[SW-1:0], {EVB{1'b0}}};
			mk_addr = '0;
		end else if (cmd.rd_next) begin
			tb_addr = {cur_x[SW-1:0], k_nxt};
			mk_addr = k_nxt;
		end else begin
			tb_addr = {cur_x[SW-1:0], in_ev};
			mk_addr = in_ev;
		end
	end

	assign tb_we    = cmd.clear || (cmd.wr_trans && in_ev_ok && src_ok);
	assign tb_re    = cmd.rd_item || cmd.rd_list || cmd.rd_next;
	assign tb_wdata = (cmd.clear || !item.entry_valid) ? '0 : {1'b1, item.target_state};
	assign mk_we    = cmd.clear || (cmd.wr_marks && in_ev_ok);
	assign mk_wdata = cmd.clear ? '0 : {item.is_controllable, item.in_alphabet};

	sup_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (2 ** AW)
	) u_table (
		.clk   (clk),
		.we    (tb_we),
		.re    (tb_re),
		.addr  (tb_addr),
		.wdata (tb_wdata),
		.rdata (tb_rdata)
	);

	sup_ram #(
		.WIDTH (MARK_W),
		.DEPTH (2 ** EVB)
	) u_marks (
		.clk   (clk),
		.we    (mk_we),
		.re    (tb_re),
		.addr  (mk_addr),
		.wdata (mk_wdata),
		.rdata (mk_rdata)
	);

	assign out_free = !m_valid_q || m_tready;
	assign in_alpha = ev_ok_q && mk_rdata[0];
	assign ent_ok   = ev_ok_q && st_ok && tb_rdata[STATE_W];
	assign moved    = in_alpha && ent_ok;
	assign hit      = mk_rdata[1] && st_ok && tb_rdata[STATE_W];
	assign pend     = cnt_q != '0;

	assign out_load = cmd.emit_step || cmd.emit_test || cmd.emit_final
		|| (cmd.list_eval && hit && pend);

	always_comb begin
		res_d             = '0;
		res_d.now_state   = cur_q;
		res_d.prior_state = prev_q;
		priority if (cmd.emit_step) begin
			res_d.result_kind = KIND_STEP;
			res_d.accepted    = !in_alpha || ent_ok;
			res_d.moved       = moved;
			res_d.last        = 1'b1;
			if (moved) begin
				res_d.now_state   = tb_rdata[STATE_W-1:0];
				res_d.prior_state = cur_q;
			end
		end else if (cmd.emit_test) begin
			res_d.result_kind   = KIND_TEST;
			res_d.event_enabled = ent_ok;
			res_d.last          = 1'b1;
		end else if (cmd.emit_final) begin
			res_d.result_kind  = KIND_LIST;
			res_d.has_event    = pend;
			res_d.listed_event = pend ? EVENT_W'(pend_ev_q) : '0;
			res_d.list_count   = cnt_q;
			res_d.last         = 1'b1;
		end else begin
			res_d.result_kind  = KIND_LIST;
			res_d.has_event    = 1'b1;
			res_d.listed_event = EVENT_W'(pend_ev_q);
			res_d.list_count   = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= '0;
			cur_q     <= '0;
			prev_q    <= '0;
			clr_q     <= '0;
			k_q       <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				init_q <= cfg_data;
			end
			if (cmd.restart) begin
				cur_q  <= init_q;
				prev_q <= init_q;
			end else if (cmd.emit_step && moved) begin
				prev_q <= cur_q;
				cur_q  <= tb_rdata[STATE_W-1:0];
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.rd_list) begin
				k_q <= '0;
			end else if (cmd.rd_next) begin
				k_q <= k_nxt;
			end
			if (cmd.rd_list) begin
				cnt_q <= '0;
			end else if (cmd.list_eval && hit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_item) begin
			ev_ok_q <= in_ev_ok;
		end
		if (cmd.list_eval && hit) begin
			pend_ev_q <= k_q;
		end
		if (out_load) begin
			res_q <= res_d;
		end
	end

	assign sts.clr_done = &clr_q;
	assign sts.out_free = out_free;
	assign sts.hit      = hit;
	assign sts.pend     = pend;
	assign sts.k_last   = k_q == EVB'(NUM_EVENTS - 1);

	assign result   = res_q;
	assign m_tvalid = m_valid_q;

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step || cmd.emit_test || cmd.emit_final) |-> out_free)
		else $error("result loaded while output slot busy");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.list_eval && hit && pend) |-> out_free)
		else $error("pending list item pushed while output slot busy");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(NUM_EVENTS))
		else $error("list count beyond event count");

	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !(cmd.rd_item || cmd.rd_list || cmd.rd_next || cmd.wr_trans
		|| cmd.wr_marks))
		else $error("table access during clearing pass");
`endif

endmodule

@@ hw/rtl/supervisor_automaton_step_top.sv @@
// step and test: the entry is read on acceptance, the result loaded in ST_STEP or ST_TEST
// once the output slot is free; list items walk one event per cycle while no new hit waits on
// a busy output slot, then ST_LIST_END loads the final result; s_tready stays low until
// the result is loaded, longer while m_tready holds it back; write and restart items stay idle
// reset: a clearing pass over 2**clog2(NUM_STATES) * 2**clog2(NUM_EVENTS) table entries (16384 by
// default) zeroes the table and event marks with s_tready low; cfg writes are taken throughout
// ----------------------------------------------------------------------------
// supervisor_automaton_step_top
// supervisor automaton stepped through a state-by-event transition table
// ----------------------------------------------------------------------------
module supervisor_automaton_step_top #(
	parameter int NUM_STATES = 256,
	parameter int NUM_EVENTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// event_id, table_state, target_state, entry_valid, in_alphabet, is_controllable
	input  logic [sup_pkg::S_DATA_W-1:0]   s_tdata,
	// action
	input  logic [sup_pkg::ACTION_W-1:0]   s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// accepted, moved, now_state, prior_state, event_enabled, has_event,
	// listed_event, list_count
	output logic [sup_pkg::M_DATA_W-1:0]   m_tdata,
	// result_kind
	output logic [sup_pkg::KIND_W-1:0]     m_tuser,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sup_pkg::STATE_W-1:0]    cfg_data
);

	import sup_pkg::*;

	item_t   item;
	result_t result;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign item.event_id        = s_tdata[5:0];
	assign item.table_state     = s_tdata[13:6];
	assign item.target_state    = s_tdata[21:14];
	assign item.entry_valid     = s_tdata[22];
	assign item.in_alphabet     = s_tdata[23];
	assign item.is_controllable = s_tdata[24];

	assign cfg_ready = 1'b1;

	sup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (action_t'(s_tuser)),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sup_dp #(
		.NUM_STATES (NUM_STATES),
		.NUM_EVENTS (NUM_EVENTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	assign m_tdata = {7'd0, result.list_count, result.listed_event, result.has_event,
		result.event_enabled, result.prior_state, result.now_state, result.moved,
		result.accepted};
	assign m_tuser = result.result_kind;
	assign m_tlast = result.last;

endmodule

@@ tb/supervisor_automaton_step_checker.sv @@
// ----------------------------------------------------------------------------
// supervisor_automaton_step_checker
// watches the item, result and cfg channels, keeps its own copy of the
// transition table, event marks and states, predicts every result and
// compares it field by field with what the block sends
// ----------------------------------------------------------------------------
module supervisor_automaton_step_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [sup_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [sup_pkg::ACTION_W-1:0] s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [sup_pkg::M_DATA_W-1:0] m_tdata,
	input  logic [sup_pkg::KIND_W-1:0]   m_tuser,
	input  logic                         m_tlast,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [sup_pkg::STATE_W-1:0]  cfg_data,
	output int                           error_count,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import sup_pkg::*;

	localparam int N_EVENTS = 2 ** EVENT_W;
	localparam int TBL_DEPTH = 2 ** (STATE_W + EVENT_W);

	logic [ENTRY_W-1:0] next_state_tbl [TBL_DEPTH];
	logic               ev_alpha [N_EVENTS];
	logic               ev_ctrl [N_EVENTS];
	logic [STATE_W-1:0] cur_st;
	logic [STATE_W-1:0] prev_st;
	logic [STATE_W-1:0] init_st;
	result_t            expected_results [$];

	task automatic push_result(input kind_t kind, input logic acc, input logic mv,
			input logic en, input logic has, input logic [EVENT_W-1:0] ev,
			input logic [COUNT_W-1:0] cnt, input logic last);
		result_t r;
		r.result_kind   = kind;
		r.accepted      = acc;
		r.moved         = mv;
		r.now_state     = cur_st;
		r.prior_state   = prev_st;
		r.event_enabled = en;
		r.has_event     = has;
		r.listed_event  = ev;
		r.list_count    = cnt;
		r.last          = last;
		expected_results.push_back(r);
	endtask

	task automatic advance_supervisor(input logic [ACTION_W-1:0] act,
			input logic [S_DATA_W-1:0] dat);
		logic [EVENT_W-1:0] ev;
		logic [STATE_W-1:0] src;
		logic [STATE_W-1:0] tgt;
		logic [ENTRY_W-1:0] entry;
		int                 n_enabled;
		int                 n_given;
		ev    = dat[5:0];
		src   = dat[13:6];
		tgt   = dat[21:14];
		entry = next_state_tbl[{cur_st, ev}];
		case (act)
			ACT_STEP: begin
				if (!ev_alpha[ev]) begin
					push_result(KIND_STEP, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
				end else if (entry[STATE_W]) begin
					prev_st = cur_st;
					cur_st  = entry[STATE_W-1:0];
					push_result(KIND_STEP, 1'b1, 1'b1, 1'b0, 1'b0, '0, '0, 1'b1);
				end else begin
					push_result(KIND_STEP, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
				end
			end
			ACT_TEST: begin
				push_result(KIND_TEST, 1'b0, 1'b0, entry[STATE_W], 1'b0, '0, '0, 1'b1);
			end
			ACT_LIST: begin
				n_enabled = 0;
				for (int k = 0; k < N_EVENTS; k++)
					if (ev_ctrl[k] && next_state_tbl[{cur_st, EVENT_W'(k)}][STATE_W])
						n_enabled++;
				n_given = 0;
				for (int k = 0; k < N_EVENTS; k++) begin
					if (ev_ctrl[k] && next_state_tbl[{cur_st, EVENT_W'(k)}][STATE_W]) begin
						n_given++;
						push_result(KIND_LIST, 1'b0, 1'b0, 1'b0, 1'b1, EVENT_W'(k),
							COUNT_W'(n_given), n_given == n_enabled);
					end
				end
				if (n_enabled == 0)
					push_result(KIND_LIST, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
			end
			ACT_WR_TRANS: begin
				next_state_tbl[{src, ev}] = dat[22] ? {1'b1, tgt} : '0;
			end
			ACT_WR_MARKS: begin
				ev_alpha[ev] = dat[23];
				ev_ctrl[ev]  = dat[24];
			end
			ACT_RESTART: begin
				cur_st  = init_st;
				prev_st = init_st;
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TBL_DEPTH; i++)
				next_state_tbl[i] = '0;
			for (int i = 0; i < N_EVENTS; i++) begin
				ev_alpha[i] = 1'b0;
				ev_ctrl[i]  = 1'b0;
			end
			cur_st  = '0;
			prev_st = '0;
			init_st = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result with no item waiting: tuser %0d tdata %h", m_tuser, m_tdata);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", want.result_kind, m_tuser);
					check_field("accepted", want.accepted, m_tdata[0]);
					check_field("moved", want.moved, m_tdata[1]);
					check_field("now_state", want.now_state, m_tdata[9:2]);
					check_field("prior_state", want.prior_state, m_tdata[17:10]);
					check_field("event_enabled", want.event_enabled, m_tdata[18]);
					check_field("has_event", want.has_event, m_tdata[19]);
					check_field("listed_event", want.listed_event, m_tdata[25:20]);
					check_field("list_count", want.list_count, m_tdata[32:26]);
					check_field("last", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready)
				advance_supervisor(s_tuser, s_tdata);
			if (cfg_valid && cfg_ready)
				init_st = cfg_data;
			pending <= expected_results.size();
		end
	end

endmodule

@@ tb/tb_supervisor_automaton_step_top.sv @@
// ----------------------------------------------------------------------------
// tb_supervisor_automaton_step_top
// drives items into the supervisor automaton block in bursts with random
// gaps while the result side stalls on its own pattern; a directed opening
// covers empty lists, blocked and ignored events, removal of transitions
// and unused actions, then random automata are built and run under several
// initial states and a full list closes; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_supervisor_automaton_step_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sup_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;
	localparam int TAIL_CYCLES = 100;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [ACTION_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]   m_tuser;
	logic                m_tlast;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [STATE_W-1:0]  cfg_data = '0;
	int                  error_count;
	int                  pending;

	rx_mode_t            rx_mode = RX_OPEN;
	int                  rx_tick = 0;
	int                  burst_left = 0;
	logic [STATE_W-1:0]  state_pool [8];
	logic [EVENT_W-1:0]  event_pool [8];

	supervisor_automaton_step_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	supervisor_automaton_step_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.error_count (error_count),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	// result side: open, coin-flip stalls or ready one time in four, switching now and then
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_RANDOM: m_tready <= 1'($urandom_range(1));
			default:   m_tready <= (rx_tick % 4) == 0;
		endcase
		if (rx_tick % 97 == 0)
			rx_mode <= rx_mode_t'($urandom_range(2));
	end

	function automatic logic [EVENT_W-1:0] any_event();
		return EVENT_W'($urandom);
	endfunction

	function automatic logic [STATE_W-1:0] any_state();
		return STATE_W'($urandom);
	endfunction

	function automatic logic any_bit();
		return 1'($urandom_range(1));
	endfunction

	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [EVENT_W-1:0] ev,
			input logic [STATE_W-1:0] src, input logic [STATE_W-1:0] tgt,
			input logic valid, input logic alpha, input logic ctrl);
		int idle;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			idle = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (idle != 0) begin
				s_tvalid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'b0, ctrl, alpha, valid, tgt, src, ev};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	task automatic hold_until_empty();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic drain_all();
		hold_until_empty();
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_initial(input logic [STATE_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		state_pool = '{v, 8'd0, 8'd255, 8'd1, 8'd2, 8'($urandom), 8'($urandom), 8'($urandom)};
		event_pool = '{6'd0, 6'd63, 6'd1, 6'($urandom), 6'($urandom), 6'($urandom),
			6'($urandom), 6'($urandom)};
	endtask

	function automatic logic [STATE_W-1:0] pick_state();
		return ($urandom_range(3) == 0) ? STATE_W'($urandom) : state_pool[$urandom_range(7)];
	endfunction

	function automatic logic [EVENT_W-1:0] pick_event();
		return ($urandom_range(3) == 0) ? EVENT_W'($urandom) : event_pool[$urandom_range(7)];
	endfunction

	task automatic start_phase(input logic [STATE_W-1:0] v);
		drain_all();
		write_initial(v);
		send_item(ACT_RESTART, any_event(), any_state(), any_state(), any_bit(), any_bit(),
			any_bit());
	endtask

	task automatic run_random(input int n_items);
		int unsigned sel;
		int          i;
		for (i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				hold_until_empty();
			sel = $urandom_range(99);
			if (sel < 12)
				send_item(ACT_WR_MARKS, pick_event(), any_state(), any_state(), any_bit(),
					$urandom_range(4) != 0, $urandom_range(2) != 0);
			else if (sel < 35)
				send_item(ACT_WR_TRANS, pick_event(), pick_state(), pick_state(),
					$urandom_range(5) != 0, any_bit(), any_bit());
			else if (sel < 65)
				send_item(ACT_STEP, pick_event(), any_state(), any_state(), any_bit(),
					any_bit(), any_bit());
			else if (sel < 78)
				send_item(ACT_TEST, pick_event(), any_state(), any_state(), any_bit(),
					any_bit(), any_bit());
			else if (sel < 90)
				send_item(ACT_LIST, any_event(), any_state(), any_state(), any_bit(),
					any_bit(), any_bit());
			else if (sel < 96)
				send_item(ACT_RESTART, any_event(), any_state(), any_state(), any_bit(),
					any_bit(), any_bit());
			else
				send_item(sel[0] ? ACT_RSVD_HI : ACT_RSVD_LO, any_event(), any_state(),
					any_state(), any_bit(), any_bit(), any_bit());
		end
	endtask

	// every event controllable and enabled from the initial state: longest list
	task automatic run_full_list();
		int k;
		for (k = 0; k < 64; k++)
			send_item(ACT_WR_MARKS, EVENT_W'(k), any_state(), any_state(), any_bit(), 1'b1,
				1'b1);
		send_item(ACT_RESTART, any_event(), any_state(), any_state(), any_bit(), any_bit(),
			any_bit());
		for (k = 0; k < 64; k++)
			send_item(ACT_WR_TRANS, EVENT_W'(k), state_pool[0], pick_state(), 1'b1,
				any_bit(), any_bit());
		send_item(ACT_LIST, any_event(), any_state(), any_state(), any_bit(), any_bit(),
			any_bit());
		send_item(ACT_TEST, 6'd31, any_state(), any_state(), any_bit(), any_bit(), any_bit());
		send_item(ACT_STEP, 6'd63, any_state(), any_state(), any_bit(), any_bit(), any_bit());
		send_item(ACT_LIST, any_event(), any_state(), any_state(), any_bit(), any_bit(),
			any_bit());
	endtask

	initial begin
		#15_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_initial(8'd0);

		// directed opening from state 0
		send_item(ACT_LIST, 6'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_STEP, 6'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_TEST, 6'd63, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_WR_MARKS, 6'd63, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
		send_item(ACT_WR_MARKS, 6'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0);
		send_item(ACT_WR_TRANS, 6'd63, 8'd0, 8'd255, 1'b1, 1'b0, 1'b0);
		send_item(ACT_WR_TRANS, 6'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
		send_item(ACT_STEP, 6'd5, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_WR_MARKS, 6'd5, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
		send_item(ACT_STEP, 6'd5, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_TEST, 6'd63, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_LIST, 6'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_STEP, 6'd63, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_WR_TRANS, 6'd5, 8'd255, 8'd128, 1'b1, 1'b0, 1'b0);
		send_item(ACT_WR_TRANS, 6'd0, 8'd255, 8'd0, 1'b1, 1'b0, 1'b0);
		send_item(ACT_LIST, 6'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_RSVD_LO, 6'd63, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
		send_item(ACT_RSVD_HI, 6'd63, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
		send_item(ACT_WR_TRANS, 6'd5, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
		send_item(ACT_TEST, 6'd5, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_STEP, 6'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_STEP, 6'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_WR_MARKS, 6'd63, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
		send_item(ACT_RESTART, 6'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_STEP, 6'd63, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		send_item(ACT_TEST, 6'd63, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);

		start_phase(8'd255);
		run_random(30);
		start_phase(STATE_W'($urandom_range(1, 254)));
		run_random(30);
		run_full_list();

		drain_all();
		@(negedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/sup_pkg.sv
hw/rtl/sup_ram.sv
hw/rtl/sup_ctrl.sv
hw/rtl/sup_dp.sv
hw/rtl/supervisor_automaton_step_top.sv
tb/supervisor_automaton_step_checker.sv
tb/tb_supervisor_automaton_step_top.sv
